// ===== hdl/sdbe_pkg.sv =====
// Shared types, codes and constants of the strobed display brightness estimator.
package sdbe_pkg;

    localparam int ROWS      = 64;
    localparam int COLS      = 64;
    localparam int ACC_W     = 32;
    localparam int BR_W      = 16;
    localparam int ADDR_W    = 13;
    localparam int LEVELS    = 4;
    localparam int QUOT_W    = 24;

    localparam logic [16:0] Q15_ONE       = 17'd32768;
    localparam logic [63:0] THR_RESET     = 64'h8000800080000148;
    localparam logic [31:0] FRAME_RESET   = 32'd16667;
    localparam logic [8:0]  BLEND_RESET   = 9'd128;
    localparam logic [8:0]  BLEND_FULL    = 9'd256;
    localparam logic [6:0]  LIMIT_64      = 7'd64;

    typedef enum logic [1:0] {
        CMD_MATRIX_WRITE = 2'd0,
        CMD_TIME_ADVANCE = 2'd1,
        CMD_EVAL_ROW     = 2'd2,
        CMD_SET_SEGMENTS = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_COLUMNS    = 3'd0,
        CFG_ROWS       = 3'd1,
        CFG_BLEND      = 3'd2,
        CFG_THRESHOLDS = 3'd3,
        CFG_CAP        = 3'd4,
        CFG_DIGIT_MIN  = 3'd5,
        CFG_FRAME      = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MW,
        S_SEG,
        S_TA_ROW,
        S_TA_RD,
        S_TA_WR,
        S_EV_ROW,
        S_EV_RD,
        S_EV_DIV0,
        S_EV_DIV,
        S_EV_MUL,
        S_EV_BLEND,
        S_EV_WR,
        S_EV_CLR,
        S_EV_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic mw_write;
        logic seg_write;
        logic row_fetch;
        logic acc_read;
        logic acc_add_write;
        logic col_inc;
        logic next_row;
        logic div_start;
        logic mul;
        logic blend;
        logic ev_write;
        logic clr_col;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd in_cmd;
        logic in_ticks_zero;
        logic in_row_unused;
        logic clr_last;
        logic mw_done;
        logic row_done;
        logic col_last;
        logic col_end;
        logic div_done;
        logic lev_last;
    } t_dp_stat;

    function automatic logic [63:0] low_mask(input logic [6:0] n);
        logic [63:0] m;
        if (n >= LIMIT_64) begin
            m = '1;
        end else begin
            m = (64'd1 << n[5:0]) - 64'd1;
        end
        return m;
    endfunction

endpackage

// ===== hdl/sdbe_div.sv =====
// Bit-serial divider: on-time times 2^15 over frame length, clipped at 2^23.
module sdbe_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_acc,
    input  logic [31:0] i_frame,
    output logic        o_done,
    output logic [23:0] o_quot
);

    logic [31:0] r_rem;
    logic [23:0] r_num;
    logic [23:0] r_quot;
    logic [31:0] r_den;
    logic        r_sat;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [32:0] trial;
    logic        take;

    assign trial = {r_rem, r_num[23]};
    assign take  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(sdbe_pkg::QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat  <= {9'd0, i_acc} >= {i_frame, 9'd0};
            r_rem  <= {9'd0, i_acc[31:9]};
            r_num  <= {i_acc[8:0], 15'd0};
            r_den  <= i_frame;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= take ? 32'(trial - {1'b0, r_den}) : trial[31:0];
            r_num  <= {r_num[22:0], 1'b0};
            r_quot <= {r_quot[22:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_sat || r_quot > 24'h800000) ? 24'h800000 : r_quot;

endmodule

// ===== hdl/sdbe_datapath.sv =====
// Datapath: configuration, row and segment stores, accumulator and brightness memories.
module sdbe_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [2:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic [1:0]           i_command,
    input  logic [5:0]           i_start_row,
    input  logic [6:0]           i_row_count,
    input  logic [63:0]          i_row_select,
    input  logic [63:0]          i_row_data,
    input  logic [31:0]          i_elapsed_ticks,
    input  logic [63:0]          i_segment_digits,
    input  logic [63:0]          i_segment_pattern,
    input  sdbe_pkg::t_dp_cmd    i_cmd,
    output sdbe_pkg::t_dp_stat   o_stat,
    output logic [5:0]           o_row_index,
    output logic [2:0]           o_level_index,
    output logic [63:0]          o_level_elements,
    output logic [63:0]          o_segment_elements,
    output logic [63:0]          o_digit_so_far,
    output logic [2:0]           o_select_level,
    output logic                 o_segments_present,
    output logic                 o_last
);

    logic [6:0]  r_columns;
    logic [6:0]  r_rows;
    logic [8:0]  r_blend;
    logic [63:0] r_thr;
    logic [15:0] r_cap;
    logic [2:0]  r_dml;
    logic [31:0] r_frame;

    logic [6:0]  r_row;
    logic [6:0]  r_col;
    logic [6:0]  r_cnt;
    logic [2:0]  r_lev;
    logic [12:0] r_clr;
    logic [63:0] r_sel_bits;
    logic [63:0] r_rd_vld;
    logic [63:0] r_seg_vld;

    logic [63:0] r_sel;
    logic [63:0] r_data;
    logic [31:0] r_ticks;
    logic [63:0] r_segdig;
    logic [63:0] r_segpat;
    logic [63:0] r_digit;
    logic [63:0] r_multi [5];
    logic [2:0]  r_sel_lev;
    logic [63:0] r_row_data;
    logic [63:0] r_row_seg;
    logic [31:0] r_acc_q;
    logic [15:0] r_br_q;
    logic [24:0] r_p1;
    logic [32:0] r_p2;
    logic [15:0] r_v;

    logic [31:0] m_acc [2**sdbe_pkg::ADDR_W];
    logic [15:0] m_br  [2**sdbe_pkg::ADDR_W];
    logic [63:0] m_rd  [sdbe_pkg::ROWS];
    logic [63:0] m_seg [sdbe_pkg::ROWS];

    logic [6:0]  cols_used;
    logic [6:0]  rows_used;
    logic [8:0]  w;
    logic [8:0]  w_inv;
    logic [31:0] frame;
    logic [15:0] thr [sdbe_pkg::LEVELS];
    logic [2:0]  nlev;
    logic [2:0]  nlev_m1;
    logic [17:0] cut_raw;
    logic [15:0] cutoff;
    logic [6:0]  height;
    logic [63:0] hmask;
    logic [63:0] sel_in;
    logic [63:0] win;
    sdbe_pkg::t_cmd in_cmd;
    logic [12:0] addr_cur;
    logic        lit;
    logic [32:0] acc_sum;
    logic [31:0] acc_sat;
    logic        acc_we;
    logic [12:0] acc_wa;
    logic [31:0] acc_wd;
    logic        br_we;
    logic [12:0] br_wa;
    logic [15:0] br_wd;
    logic [33:0] blend_sum;
    logic [25:0] blend_sh;
    logic [15:0] blend_v;
    logic [2:0]  lev;
    logic [63:0] seg_el;
    logic [63:0] digit_now;
    logic        div_done;
    logic [23:0] div_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= '0;
            r_rows    <= '0;
            r_blend   <= sdbe_pkg::BLEND_RESET;
            r_thr     <= sdbe_pkg::THR_RESET;
            r_cap     <= '0;
            r_dml     <= '0;
            r_frame   <= sdbe_pkg::FRAME_RESET;
        end else if (i_cfg_valid) begin
            case (sdbe_pkg::t_cfg_idx'(i_cfg_index))
                sdbe_pkg::CFG_COLUMNS:    r_columns <= i_cfg_data[6:0];
                sdbe_pkg::CFG_ROWS:       r_rows    <= i_cfg_data[6:0];
                sdbe_pkg::CFG_BLEND:      r_blend   <= i_cfg_data[8:0];
                sdbe_pkg::CFG_THRESHOLDS: r_thr     <= i_cfg_data;
                sdbe_pkg::CFG_CAP:        r_cap     <= i_cfg_data[15:0];
                sdbe_pkg::CFG_DIGIT_MIN:  r_dml     <= i_cfg_data[2:0];
                sdbe_pkg::CFG_FRAME:      r_frame   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign cols_used = (r_columns > sdbe_pkg::LIMIT_64) ? sdbe_pkg::LIMIT_64 : r_columns;
    assign rows_used = (r_rows > sdbe_pkg::LIMIT_64) ? sdbe_pkg::LIMIT_64 : r_rows;
    assign w         = (r_blend > sdbe_pkg::BLEND_FULL) ? sdbe_pkg::BLEND_FULL : r_blend;
    assign w_inv     = sdbe_pkg::BLEND_FULL - w;
    assign frame     = (r_frame == '0) ? 32'd1 : r_frame;

    for (genvar i = 0; i < sdbe_pkg::LEVELS; i++) begin : g_thr
        assign thr[i] = r_thr[16*i +: 16];
    end

    always_comb begin
        if (thr[1][15]) begin
            nlev = 3'd1;
        end else if (thr[2][15]) begin
            nlev = 3'd2;
        end else if (thr[3][15]) begin
            nlev = 3'd3;
        end else begin
            nlev = 3'd4;
        end
    end

    assign nlev_m1 = nlev - 3'd1;
    assign cut_raw = (r_cap == '0) ? {thr[nlev_m1[1:0]], 2'b00} : {2'b00, r_cap};
    assign cutoff  = (cut_raw > 18'(sdbe_pkg::Q15_ONE)) ? 16'h8000 : cut_raw[15:0];

    assign in_cmd = sdbe_pkg::t_cmd'(i_command);
    assign height = (i_row_count > sdbe_pkg::LIMIT_64) ? sdbe_pkg::LIMIT_64 : i_row_count;
    assign hmask  = sdbe_pkg::low_mask(height);
    assign sel_in = i_row_select & hmask;
    assign win    = hmask << i_start_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_cnt      <= '0;
            r_lev      <= '0;
            r_clr      <= '0;
            r_sel_bits <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_row <= (in_cmd == sdbe_pkg::CMD_MATRIX_WRITE ||
                          in_cmd == sdbe_pkg::CMD_EVAL_ROW) ? {1'b0, i_start_row} : 7'd0;
                r_col <= '0;
                r_cnt <= height;
                r_lev <= '0;
                if (in_cmd == sdbe_pkg::CMD_MATRIX_WRITE) begin
                    r_sel_bits <= (r_sel_bits & ~win) | (sel_in << i_start_row);
                end
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 13'd1;
            end
            if (i_cmd.mw_write) begin
                r_row <= r_row + 7'd1;
                r_cnt <= r_cnt - 7'd1;
            end
            if (i_cmd.seg_write || i_cmd.next_row) begin
                r_row <= r_row + 7'd1;
            end
            if (i_cmd.row_fetch) begin
                r_col <= '0;
            end
            if (i_cmd.col_inc || i_cmd.clr_col) begin
                r_col <= r_col + 7'd1;
            end
            if (i_cmd.emit) begin
                r_lev <= r_lev + 3'd1;
            end
        end
    end

    assign blend_sum = {9'd0, r_p1} + {1'b0, r_p2};
    assign blend_sh  = blend_sum[33:8];
    assign blend_v   = (blend_sh > {10'd0, cutoff}) ? cutoff : blend_sh[15:0];

    always_comb begin
        if (r_v <= thr[0]) begin
            lev = 3'd0;
        end else if (r_v <= thr[1]) begin
            lev = 3'd1;
        end else if (r_v <= thr[2]) begin
            lev = 3'd2;
        end else if (r_v <= thr[3]) begin
            lev = 3'd3;
        end else begin
            lev = 3'd4;
        end
    end

    assign seg_el    = r_multi[r_lev] & r_row_seg;
    assign digit_now = (r_lev > r_dml) ? (r_digit | seg_el) : r_digit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sel    <= sel_in;
            r_data   <= i_row_data & sdbe_pkg::low_mask(cols_used);
            r_ticks  <= i_elapsed_ticks;
            r_segdig <= i_segment_digits;
            r_segpat <= i_segment_pattern;
            r_digit  <= '0;
            for (int i = 0; i < 5; i++) begin
                r_multi[i] <= '0;
            end
        end
        if (i_cmd.mw_write) begin
            r_sel <= r_sel >> 1;
        end
        if (i_cmd.mul) begin
            r_p1 <= r_br_q * w_inv;
            r_p2 <= div_quot * w;
        end
        if (i_cmd.blend) begin
            r_v <= blend_v;
        end
        if (i_cmd.ev_write) begin
            if (r_col == cols_used) begin
                r_sel_lev <= lev;
            end else begin
                r_multi[lev][r_col[5:0]] <= 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_digit <= digit_now;
        end
    end

    assign addr_cur = {r_row[5:0], r_col};
    assign lit      = (r_col == cols_used) ? r_sel_bits[r_row[5:0]] : r_row_data[r_col[5:0]];
    assign acc_sum  = {1'b0, r_acc_q} + {1'b0, r_ticks};
    assign acc_sat  = acc_sum[32] ? '1 : acc_sum[31:0];

    always_comb begin
        acc_we = 1'b0;
        acc_wa = addr_cur;
        acc_wd = '0;
        br_we  = 1'b0;
        br_wa  = addr_cur;
        br_wd  = r_v;
        if (i_cmd.clr_step) begin
            acc_we = 1'b1;
            acc_wa = r_clr;
            br_we  = 1'b1;
            br_wa  = r_clr;
            br_wd  = '0;
        end else if (i_cmd.acc_add_write) begin
            acc_we = lit;
            acc_wd = acc_sat;
        end else if (i_cmd.ev_write || i_cmd.clr_col) begin
            acc_we = 1'b1;
            br_we  = i_cmd.ev_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            m_acc[acc_wa] <= acc_wd;
        end
        if (i_cmd.acc_read) begin
            r_acc_q <= m_acc[addr_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (br_we) begin
            m_br[br_wa] <= br_wd;
        end
        if (i_cmd.acc_read) begin
            r_br_q <= m_br[addr_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= '0;
            r_seg_vld <= '0;
        end else begin
            if (i_cmd.mw_write) begin
                r_rd_vld[r_row[5:0]] <= 1'b1;
            end
            if (i_cmd.seg_write && r_segdig[r_row[5:0]]) begin
                r_seg_vld[r_row[5:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mw_write) begin
            m_rd[r_row[5:0]] <= r_sel[0] ? r_data : 64'd0;
        end
        if (i_cmd.row_fetch) begin
            r_row_data <= r_rd_vld[r_row[5:0]] ? m_rd[r_row[5:0]] : 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seg_write && r_segdig[r_row[5:0]]) begin
            m_seg[r_row[5:0]] <= r_segpat;
        end
        if (i_cmd.row_fetch) begin
            r_row_seg <= r_seg_vld[r_row[5:0]] ? m_seg[r_row[5:0]] : 64'd0;
        end
    end

    sdbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_acc   (r_acc_q),
        .i_frame (frame),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_stat.in_cmd        = in_cmd;
    assign o_stat.in_ticks_zero = (i_elapsed_ticks == '0);
    assign o_stat.in_row_unused = ({1'b0, i_start_row} >= rows_used);
    assign o_stat.clr_last      = &r_clr;
    assign o_stat.mw_done       = (r_cnt == '0) || (r_row >= rows_used);
    assign o_stat.row_done      = (r_row >= rows_used);
    assign o_stat.col_last      = (r_col == cols_used);
    assign o_stat.col_end       = (r_col > sdbe_pkg::LIMIT_64);
    assign o_stat.div_done      = div_done;
    assign o_stat.lev_last      = (r_lev == nlev);

    assign o_row_index        = r_row[5:0];
    assign o_level_index      = r_lev;
    assign o_level_elements   = r_multi[r_lev];
    assign o_segment_elements = seg_el;
    assign o_digit_so_far     = digit_now;
    assign o_select_level     = r_sel_lev;
    assign o_segments_present = |r_row_seg;
    assign o_last             = (r_lev == nlev);

endmodule

// ===== hdl/sdbe_ctrl.sv =====
// Controller state machine sequencing the datapath for each command.
module sdbe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  sdbe_pkg::t_dp_stat  i_stat,
    output sdbe_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy,
    output logic                o_result_valid
);

    sdbe_pkg::t_state r_state;
    sdbe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdbe_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sdbe_pkg::S_CLEAR: begin
                if (i_stat.clr_last) n_state = sdbe_pkg::S_IDLE;
            end
            sdbe_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_stat.in_cmd)
                        sdbe_pkg::CMD_MATRIX_WRITE: n_state = sdbe_pkg::S_MW;
                        sdbe_pkg::CMD_TIME_ADVANCE: begin
                            n_state = i_stat.in_ticks_zero ? sdbe_pkg::S_IDLE
                                                           : sdbe_pkg::S_TA_ROW;
                        end
                        sdbe_pkg::CMD_EVAL_ROW: begin
                            n_state = i_stat.in_row_unused ? sdbe_pkg::S_IDLE
                                                           : sdbe_pkg::S_EV_ROW;
                        end
                        sdbe_pkg::CMD_SET_SEGMENTS: n_state = sdbe_pkg::S_SEG;
                        default: n_state = sdbe_pkg::S_IDLE;
                    endcase
                end
            end
            sdbe_pkg::S_MW: begin
                if (i_stat.mw_done) n_state = sdbe_pkg::S_IDLE;
            end
            sdbe_pkg::S_SEG: begin
                if (i_stat.row_done) n_state = sdbe_pkg::S_IDLE;
            end
            sdbe_pkg::S_TA_ROW: begin
                n_state = i_stat.row_done ? sdbe_pkg::S_IDLE : sdbe_pkg::S_TA_RD;
            end
            sdbe_pkg::S_TA_RD:   n_state = sdbe_pkg::S_TA_WR;
            sdbe_pkg::S_TA_WR: begin
                n_state = i_stat.col_last ? sdbe_pkg::S_TA_ROW : sdbe_pkg::S_TA_RD;
            end
            sdbe_pkg::S_EV_ROW:  n_state = sdbe_pkg::S_EV_RD;
            sdbe_pkg::S_EV_RD:   n_state = sdbe_pkg::S_EV_DIV0;
            sdbe_pkg::S_EV_DIV0: n_state = sdbe_pkg::S_EV_DIV;
            sdbe_pkg::S_EV_DIV: begin
                if (i_stat.div_done) n_state = sdbe_pkg::S_EV_MUL;
            end
            sdbe_pkg::S_EV_MUL:   n_state = sdbe_pkg::S_EV_BLEND;
            sdbe_pkg::S_EV_BLEND: n_state = sdbe_pkg::S_EV_WR;
            sdbe_pkg::S_EV_WR: begin
                n_state = i_stat.col_last ? sdbe_pkg::S_EV_CLR : sdbe_pkg::S_EV_RD;
            end
            sdbe_pkg::S_EV_CLR: begin
                if (i_stat.col_end) n_state = sdbe_pkg::S_EV_EMIT;
            end
            sdbe_pkg::S_EV_EMIT: begin
                if (i_stat.lev_last) n_state = sdbe_pkg::S_IDLE;
            end
            default: n_state = sdbe_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_busy         = 1'b1;
        o_result_valid = 1'b0;
        case (r_state)
            sdbe_pkg::S_CLEAR: o_cmd.clr_step = 1'b1;
            sdbe_pkg::S_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            sdbe_pkg::S_MW:     o_cmd.mw_write  = !i_stat.mw_done;
            sdbe_pkg::S_SEG:    o_cmd.seg_write = !i_stat.row_done;
            sdbe_pkg::S_TA_ROW: o_cmd.row_fetch = !i_stat.row_done;
            sdbe_pkg::S_TA_RD:  o_cmd.acc_read  = 1'b1;
            sdbe_pkg::S_TA_WR: begin
                o_cmd.acc_add_write = 1'b1;
                o_cmd.next_row      = i_stat.col_last;
                o_cmd.col_inc       = !i_stat.col_last;
            end
            sdbe_pkg::S_EV_ROW:   o_cmd.row_fetch = 1'b1;
            sdbe_pkg::S_EV_RD:    o_cmd.acc_read  = 1'b1;
            sdbe_pkg::S_EV_DIV0:  o_cmd.div_start = 1'b1;
            sdbe_pkg::S_EV_DIV:   ;
            sdbe_pkg::S_EV_MUL:   o_cmd.mul       = 1'b1;
            sdbe_pkg::S_EV_BLEND: o_cmd.blend     = 1'b1;
            sdbe_pkg::S_EV_WR: begin
                o_cmd.ev_write = 1'b1;
                o_cmd.col_inc  = 1'b1;
            end
            sdbe_pkg::S_EV_CLR: o_cmd.clr_col = !i_stat.col_end;
            sdbe_pkg::S_EV_EMIT: begin
                o_cmd.emit     = 1'b1;
                o_result_valid = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/strobed_display_brightness_estimator_top.sv =====
// Top level of the strobed display brightness estimator.
// Reset sweeps the accumulator and brightness memories to zero, with busy high.
// Matrix write stores the selected rows in order; segment mask write steps through all used rows.
// Time advance walks every used row with one read and one write per column.
// Row evaluation: each column is read, divided, blended and written back, then the
// remaining accumulator columns are cleared; one result a cycle, never stalled by the receiver.
module strobed_display_brightness_estimator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic [1:0]  i_command,
    input  logic [5:0]  i_start_row,
    input  logic [6:0]  i_row_count,
    input  logic [63:0] i_row_select,
    input  logic [63:0] i_row_data,
    input  logic [31:0] i_elapsed_ticks,
    input  logic [63:0] i_segment_digits,
    input  logic [63:0] i_segment_pattern,
    output logic        o_result_valid,
    output logic [5:0]  o_row_index,
    output logic [2:0]  o_level_index,
    output logic [63:0] o_level_elements,
    output logic [63:0] o_segment_elements,
    output logic [63:0] o_digit_so_far,
    output logic [2:0]  o_select_level,
    output logic        o_segments_present,
    output logic        o_last
);

    sdbe_pkg::t_dp_cmd  dp_cmd;
    sdbe_pkg::t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    sdbe_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_stat         (dp_stat),
        .o_cmd          (dp_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    sdbe_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_command          (i_command),
        .i_start_row        (i_start_row),
        .i_row_count        (i_row_count),
        .i_row_select       (i_row_select),
        .i_row_data         (i_row_data),
        .i_elapsed_ticks    (i_elapsed_ticks),
        .i_segment_digits   (i_segment_digits),
        .i_segment_pattern  (i_segment_pattern),
        .i_cmd              (dp_cmd),
        .o_stat             (dp_stat),
        .o_row_index        (o_row_index),
        .o_level_index      (o_level_index),
        .o_level_elements   (o_level_elements),
        .o_segment_elements (o_segment_elements),
        .o_digit_so_far     (o_digit_so_far),
        .o_select_level     (o_select_level),
        .o_segments_present (o_segments_present),
        .o_last             (o_last)
    );

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobed while idle");

    a_levels_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last |=> o_result_valid)
        else $error("gap inside a row's level results");

    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last |=> !o_result_valid)
        else $error("result after last level");

    a_level_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && $past(o_result_valid) |->
            o_level_index == $past(o_level_index) + 3'd1)
        else $error("level index did not advance by one");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_level_index <= 3'd4)
        else $error("level index out of range");

endmodule

// ===== test/tb_strobed_display_brightness_estimator_top.sv =====
`timescale 1ns / 100ps
// Testbench for the strobed display brightness estimator: directed table plus random commands, scoreboard check.
module tb_strobed_display_brightness_estimator_top;

    typedef struct packed {
        logic [5:0]  row;
        logic [2:0]  lev;
        logic [63:0] lev_el;
        logic [63:0] seg_el;
        logic [63:0] digit;
        logic [2:0]  sel_lev;
        logic        seg_pres;
        logic        fin;
    } t_level_res;

    typedef struct {
        sdbe_pkg::t_cmd cmd;
        logic [5:0]  row;
        logic [6:0]  cnt;
        logic [63:0] sel;
        logic [63:0] data;
        logic [31:0] ticks;
        logic [63:0] digits;
        logic [63:0] pattern;
        int          n_known;
        logic [63:0] known_lev_el;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic [1:0]  i_command = '0;
    logic [5:0]  i_start_row = '0;
    logic [6:0]  i_row_count = '0;
    logic [63:0] i_row_select = '0;
    logic [63:0] i_row_data = '0;
    logic [31:0] i_elapsed_ticks = '0;
    logic [63:0] i_segment_digits = '0;
    logic [63:0] i_segment_pattern = '0;
    logic        o_result_valid;
    logic [5:0]  o_row_index;
    logic [2:0]  o_level_index;
    logic [63:0] o_level_elements;
    logic [63:0] o_segment_elements;
    logic [63:0] o_digit_so_far;
    logic [2:0]  o_select_level;
    logic        o_segments_present;
    logic        o_last;

    logic [6:0]  m_cols, m_rows;
    logic [8:0]  m_blend;
    logic [63:0] m_thr;
    logic [15:0] m_cap;
    logic [2:0]  m_dmin;
    logic [31:0] m_frame;
    logic [63:0] m_sel_bits;
    logic [63:0] m_data[64];
    logic [31:0] m_acc[64][65];
    logic [15:0] m_bright[64][65];
    logic [63:0] m_row_seg[64];

    t_level_res  pending_levels[$];
    int          errors = 0;
    int          n_results = 0;
    int          n_items = 0;
    int          n_evals = 0;
    bit          no_idle = 1'b0;

    strobed_display_brightness_estimator_top u_dut (.*);

    always #10 i_clk = ~i_clk;

    initial begin
        #400ms;
        $display("strobed_display_brightness_estimator_top verification failed");
        $finish;
    end

    function automatic int used_cols();
        return m_cols > 64 ? 64 : int'(m_cols);
    endfunction

    function automatic int used_rows();
        return m_rows > 64 ? 64 : int'(m_rows);
    endfunction

    function automatic logic [16:0] thr_at(int i);
        return i >= sdbe_pkg::LEVELS ? sdbe_pkg::Q15_ONE : {1'b0, m_thr[16*i +: 16]};
    endfunction

    function automatic logic [63:0] mask_n(int n);
        return n >= 64 ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    task automatic model_reset();
        m_cols = '0; m_rows = '0; m_blend = sdbe_pkg::BLEND_RESET; m_thr = sdbe_pkg::THR_RESET;
        m_cap = '0; m_dmin = '0; m_frame = sdbe_pkg::FRAME_RESET; m_sel_bits = '0;
        for (int y = 0; y < 64; y++) begin
            m_data[y] = '0;
            m_row_seg[y] = '0;
            for (int x = 0; x <= 64; x++) begin
                m_acc[y][x] = '0;
                m_bright[y][x] = '0;
            end
        end
    endtask

    task automatic add_on_time(int y, int x, logic [31:0] d);
        logic [32:0] s;
        s = {1'b0, m_acc[y][x]} + {1'b0, d};
        m_acc[y][x] = s[32] ? '1 : s[31:0];
    endtask

    task automatic eval_row_levels(int y);
        int          cols, nlev, lev;
        logic [63:0] cutoff, w, frame, r, v, segm, digit;
        logic [63:0] multi[5];
        logic [2:0]  sel_lev;
        t_level_res  res;
        cols = used_cols();
        nlev = 1;
        digit = '0;
        sel_lev = '0;
        while (nlev < sdbe_pkg::LEVELS && thr_at(nlev) < sdbe_pkg::Q15_ONE) nlev++;
        cutoff = 64'(m_cap);
        if (cutoff == 0) cutoff = 64'(thr_at(nlev - 1)) << 2;
        if (cutoff > sdbe_pkg::Q15_ONE) cutoff = 64'(sdbe_pkg::Q15_ONE);
        w = m_blend > sdbe_pkg::BLEND_FULL ? 64'(sdbe_pkg::BLEND_FULL) : 64'(m_blend);
        frame = m_frame == 0 ? 64'd1 : 64'(m_frame);
        for (int b = 0; b < 5; b++) multi[b] = '0;
        for (int x = 0; x <= cols; x++) begin
            r = ({32'd0, m_acc[y][x]} << 15) / frame;
            if (r > 64'd8388608) r = 64'd8388608;
            v = (64'(m_bright[y][x]) * (64'd256 - w) + r * w) >> 8;
            if (v > cutoff) v = cutoff;
            m_bright[y][x] = v[15:0];
            lev = 0;
            while (lev < sdbe_pkg::LEVELS && v > thr_at(lev)) lev++;
            if (x != cols) multi[lev][x] = 1'b1;
            else sel_lev = lev[2:0];
        end
        for (int b = 0; b <= nlev; b++) begin
            segm = multi[b] & m_row_seg[y];
            if (b > m_dmin) digit |= segm;
            res.row = y[5:0];
            res.lev = b[2:0];
            res.lev_el = multi[b];
            res.seg_el = segm;
            res.digit = digit;
            res.sel_lev = sel_lev;
            res.seg_pres = m_row_seg[y] != 0;
            res.fin = b == nlev;
            pending_levels.push_back(res);
        end
        for (int x = 0; x <= 64; x++) m_acc[y][x] = '0;
    endtask

    task automatic predict_command(t_stim_row s);
        int          rows, cols, h;
        logic [63:0] sel, data, win;
        rows = used_rows();
        cols = used_cols();
        h = s.cnt > 64 ? 64 : int'(s.cnt);
        case (s.cmd)
            sdbe_pkg::CMD_MATRIX_WRITE: begin
                sel = s.sel & mask_n(h);
                data = s.data & mask_n(cols);
                win = mask_n(h) << s.row;
                m_sel_bits = (m_sel_bits & ~win) | (sel << s.row);
                for (int y = s.row; y < s.row + h && y < rows; y++) begin
                    m_data[y] = sel[0] ? data : '0;
                    sel >>= 1;
                end
            end
            sdbe_pkg::CMD_TIME_ADVANCE: begin
                if (s.ticks != 0) begin
                    for (int y = 0; y < rows; y++) begin
                        if (m_sel_bits[y]) add_on_time(y, cols, s.ticks);
                        for (int x = 0; x < cols; x++)
                            if (m_data[y][x]) add_on_time(y, x, s.ticks);
                    end
                end
            end
            sdbe_pkg::CMD_EVAL_ROW: begin
                if (s.row < rows) begin
                    eval_row_levels(s.row);
                    n_evals++;
                end
            end
            default: begin
                for (int y = 0; y < rows; y++)
                    if (s.digits[y]) m_row_seg[y] = s.pattern;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_level_res exp_res;
        if (i_rst_n && o_result_valid) begin
            n_results++;
            if (pending_levels.size() == 0) begin
                $error("unexpected result row %0d level %0d", o_row_index, o_level_index);
                errors++;
            end else begin
                exp_res = pending_levels.pop_front();
                if (o_row_index !== exp_res.row) begin
                    $error("row_index exp %0d got %0d", exp_res.row, o_row_index);
                    errors++;
                end
                if (o_level_index !== exp_res.lev) begin
                    $error("level_index exp %0d got %0d", exp_res.lev, o_level_index);
                    errors++;
                end
                if (o_level_elements !== exp_res.lev_el) begin
                    $error("level_elements exp %h got %h", exp_res.lev_el, o_level_elements);
                    errors++;
                end
                if (o_segment_elements !== exp_res.seg_el) begin
                    $error("segment_elements exp %h got %h", exp_res.seg_el,
                           o_segment_elements);
                    errors++;
                end
                if (o_digit_so_far !== exp_res.digit) begin
                    $error("digit_so_far exp %h got %h", exp_res.digit, o_digit_so_far);
                    errors++;
                end
                if (o_select_level !== exp_res.sel_lev) begin
                    $error("select_level exp %0d got %0d", exp_res.sel_lev, o_select_level);
                    errors++;
                end
                if (o_segments_present !== exp_res.seg_pres) begin
                    $error("segments_present exp %0d got %0d", exp_res.seg_pres,
                           o_segments_present);
                    errors++;
                end
                if (o_last !== exp_res.fin) begin
                    $error("last exp %0d got %0d", exp_res.fin, o_last);
                    errors++;
                end
            end
        end
    end

    task automatic idle_gap();
        while (!no_idle && $urandom_range(99) < 16) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(sdbe_pkg::t_cfg_idx idx, logic [63:0] value);
        idle_gap();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            sdbe_pkg::CFG_COLUMNS:    m_cols = value[6:0];
            sdbe_pkg::CFG_ROWS:       m_rows = value[6:0];
            sdbe_pkg::CFG_BLEND:      m_blend = value[8:0];
            sdbe_pkg::CFG_THRESHOLDS: m_thr = value;
            sdbe_pkg::CFG_CAP:        m_cap = value[15:0];
            sdbe_pkg::CFG_DIGIT_MIN:  m_dmin = value[2:0];
            default:                  m_frame = value[31:0];
        endcase
        @(negedge i_clk);
    endtask

    task automatic send_command(t_stim_row s);
        idle_gap();
        i_cfg_valid <= 1'b0;
        i_command <= s.cmd;
        i_start_row <= s.row;
        i_row_count <= s.cnt;
        i_row_select <= s.sel;
        i_row_data <= s.data;
        i_elapsed_ticks <= s.ticks;
        i_segment_digits <= s.digits;
        i_segment_pattern <= s.pattern;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_command(s);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_levels.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        while (busy && guard < 400000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (20) @(negedge i_clk);
    endtask

    function automatic t_stim_row mk(sdbe_pkg::t_cmd c, int row, int cnt, logic [63:0] sel,
                                     logic [63:0] data, logic [31:0] ticks,
                                     logic [63:0] digits, logic [63:0] pattern);
        t_stim_row s;
        s.cmd = c; s.row = row[5:0]; s.cnt = cnt[6:0]; s.sel = sel; s.data = data;
        s.ticks = ticks; s.digits = digits; s.pattern = pattern;
        s.n_known = -1; s.known_lev_el = '0;
        return s;
    endfunction

    function automatic t_stim_row rand_cmd(int rows);
        t_stim_row s;
        int        k;
        k = $urandom_range(99);
        s = mk(sdbe_pkg::CMD_MATRIX_WRITE, $urandom_range(63), $urandom_range(127),
               {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
               {$urandom, $urandom}, {$urandom, $urandom});
        if (k < 30) begin
            s.cmd = sdbe_pkg::CMD_MATRIX_WRITE;
            if ($urandom_range(3) != 0) s.row = 6'($urandom_range(rows > 0 ? rows - 1 : 0));
            if ($urandom_range(3) != 0) s.cnt = 7'($urandom_range(8));
        end else if (k < 60) begin
            s.cmd = sdbe_pkg::CMD_TIME_ADVANCE;
            if ($urandom_range(3) != 0) s.ticks = $urandom_range(20000);
        end else if (k < 90) begin
            s.cmd = sdbe_pkg::CMD_EVAL_ROW;
            if ($urandom_range(7) != 0) s.row = 6'($urandom_range(rows > 0 ? rows - 1 : 0));
        end else begin
            s.cmd = sdbe_pkg::CMD_SET_SEGMENTS;
        end
        return s;
    endfunction

    initial begin
        t_stim_row dir_tab[$];
        int        rows_set;
        model_reset();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_reg(sdbe_pkg::CFG_COLUMNS, 64'd8);
        write_reg(sdbe_pkg::CFG_ROWS, 64'd4);
        write_reg(sdbe_pkg::CFG_FRAME, 64'd100);

        // directed: reset state evaluates to all columns at level 0
        dir_tab.push_back(mk(sdbe_pkg::CMD_EVAL_ROW, 0, 0, 0, 0, 0, 0, 0));
        dir_tab[$].n_known = 2;
        dir_tab[$].known_lev_el = 64'hFF;
        dir_tab.push_back(mk(sdbe_pkg::CMD_SET_SEGMENTS, 0, 0, 0, 0, 0, '1, 64'h0F));
        dir_tab.push_back(mk(sdbe_pkg::CMD_MATRIX_WRITE, 0, 4, 64'hF, 64'hA5, 0, 0, 0));
        dir_tab.push_back(mk(sdbe_pkg::CMD_MATRIX_WRITE, 63, 127, '1, '1, 0, 0, 0));
        dir_tab.push_back(mk(sdbe_pkg::CMD_TIME_ADVANCE, 0, 0, 0, 0, 32'd0, 0, 0));
        dir_tab.push_back(mk(sdbe_pkg::CMD_TIME_ADVANCE, 0, 0, 0, 0, 32'd50, 0, 0));
        dir_tab.push_back(mk(sdbe_pkg::CMD_TIME_ADVANCE, 0, 0, 0, 0, '1, 0, 0));
        dir_tab.push_back(mk(sdbe_pkg::CMD_TIME_ADVANCE, 0, 0, 0, 0, '1, 0, 0));
        dir_tab.push_back(mk(sdbe_pkg::CMD_EVAL_ROW, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(sdbe_pkg::CMD_EVAL_ROW, 3, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(sdbe_pkg::CMD_EVAL_ROW, 63, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(sdbe_pkg::CMD_MATRIX_WRITE, 1, 2, 64'h1, '1, 0, 0, 0));
        dir_tab.push_back(mk(sdbe_pkg::CMD_TIME_ADVANCE, 0, 0, 0, 0, 32'd30, 0, 0));
        dir_tab.push_back(mk(sdbe_pkg::CMD_EVAL_ROW, 1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(sdbe_pkg::CMD_EVAL_ROW, 2, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(sdbe_pkg::CMD_SET_SEGMENTS, 0, 0, 0, 0, 0, '1, '1));
        dir_tab.push_back(mk(sdbe_pkg::CMD_EVAL_ROW, 1, 0, 0, 0, 0, 0, 0));

        foreach (dir_tab[i]) begin
            int before_n;
            before_n = pending_levels.size();
            send_command(dir_tab[i]);
            if (dir_tab[i].n_known >= 0) begin
                if (pending_levels.size() - before_n != dir_tab[i].n_known ||
                    pending_levels[before_n].lev_el !== dir_tab[i].known_lev_el) begin
                    $error("level_elements exp %h got %h", dir_tab[i].known_lev_el,
                           pending_levels[before_n].lev_el);
                    errors++;
                end
            end
        end
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(sdbe_pkg::CFG_BLEND, 64'd256);
                    write_reg(sdbe_pkg::CFG_THRESHOLDS, 64'h2000_1000_0800_0100);
                    write_reg(sdbe_pkg::CFG_CAP, 64'd0);
                    write_reg(sdbe_pkg::CFG_DIGIT_MIN, 64'd1);
                    write_reg(sdbe_pkg::CFG_COLUMNS, 64'd64);
                    write_reg(sdbe_pkg::CFG_ROWS, 64'd6);
                end
                1: begin
                    write_reg(sdbe_pkg::CFG_BLEND, 64'h1FF);
                    write_reg(sdbe_pkg::CFG_CAP, 64'hFFFF);
                    write_reg(sdbe_pkg::CFG_DIGIT_MIN, 64'd7);
                    write_reg(sdbe_pkg::CFG_FRAME, 64'd0);
                    write_reg(sdbe_pkg::CFG_COLUMNS, 64'h7F);
                    write_reg(sdbe_pkg::CFG_ROWS, 64'd3);
                    no_idle = 1'b1;
                end
                2: begin
                    no_idle = 1'b0;
                    write_reg(sdbe_pkg::CFG_BLEND, 64'd0);
                    write_reg(sdbe_pkg::CFG_THRESHOLDS, {$urandom, $urandom});
                    write_reg(sdbe_pkg::CFG_CAP, 64'd32768);
                    write_reg(sdbe_pkg::CFG_DIGIT_MIN, 64'd0);
                    write_reg(sdbe_pkg::CFG_FRAME, 64'hFFFF_FFFF);
                    write_reg(sdbe_pkg::CFG_COLUMNS, 64'd0);
                    write_reg(sdbe_pkg::CFG_ROWS, 64'h7F);
                end
                3: begin
                    write_reg(sdbe_pkg::CFG_BLEND, 64'd77);
                    write_reg(sdbe_pkg::CFG_THRESHOLDS, 64'h8000_9000_4000_0200);
                    write_reg(sdbe_pkg::CFG_CAP, 64'd1);
                    write_reg(sdbe_pkg::CFG_DIGIT_MIN, 64'd4);
                    write_reg(sdbe_pkg::CFG_FRAME, 64'd5000);
                    write_reg(sdbe_pkg::CFG_COLUMNS, 64'd16);
                    write_reg(sdbe_pkg::CFG_ROWS, 64'd0);
                end
                default: begin
                    write_reg(sdbe_pkg::CFG_BLEND, 64'd200);
                    write_reg(sdbe_pkg::CFG_THRESHOLDS, 64'hFFFF_6000_3000_1000);
                    write_reg(sdbe_pkg::CFG_CAP, 64'd20000);
                    write_reg(sdbe_pkg::CFG_DIGIT_MIN, 64'd2);
                    write_reg(sdbe_pkg::CFG_FRAME, 64'd16667);
                    write_reg(sdbe_pkg::CFG_COLUMNS, 64'd12);
                    write_reg(sdbe_pkg::CFG_ROWS, 64'd64);
                end
            endcase
            rows_set = used_rows();
            for (int n = 0; n < 32; n++) begin
                send_command(rand_cmd(rows_set));
                if (phase == 0 && n == 16) drain();
            end
            drain();
        end

        $display("covered %0d commands with %0d row evaluations and %0d level results",
                 n_items, n_evals, n_results);
        $display("across five register settings including field extremes");
        if (errors == 0 && pending_levels.size() == 0) begin
            $display("strobed_display_brightness_estimator_top verification clean");
        end else begin
            $display("strobed_display_brightness_estimator_top verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sdbe_pkg.sv
hdl/sdbe_div.sv
hdl/sdbe_datapath.sv
hdl/sdbe_ctrl.sv
hdl/strobed_display_brightness_estimator_top.sv
test/tb_strobed_display_brightness_estimator_top.sv
